[hw/rtl/sorted_unique_set_macros.svh]
`ifndef SORTED_UNIQUE_SET_MACROS_SVH
`define SORTED_UNIQUE_SET_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define SUS_ASSERT_SAME(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("sorted_unique_set: same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define SUS_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("sorted_unique_set: next-cycle check failed");

`endif

[hw/rtl/sus_pkg.sv]
package sus_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic                     lt;
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } cell_link_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic                     load_flags;
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } cell_cmd_t;

  // What a cell reports back to the control.
  typedef struct packed {
    logic              eq;
    logic [DATA_W-1:0] rd_value;
  } cell_stat_t;

endpackage

[hw/rtl/sus_cell.sv]
module sus_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  sus_pkg::cell_cmd_t  cmd,
  input  sus_pkg::cell_link_t left,
  input  sus_pkg::cell_link_t right,
  output sus_pkg::cell_link_t link,
  output sus_pkg::cell_stat_t stat
);

  localparam logic [31:0] RANK = 32'(INDEX + 1);

  logic signed [sus_pkg::DATA_W-1:0] value;
  logic                              valid;
  logic                              lt;
  logic                              eq;
  logic                              ge;
  logic                              at;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      valid <= valid | left.valid;
    end else if (cmd.rem && ge) begin
      valid <= right.valid;
    end
  end

  // On insert, the first cell not below the new value takes it and the cells
  // after it move one place to the right; on remove, cells at or past the
  // rank take the entry of their right neighbor.
  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      value <= left.lt ? cmd.value : left.value;
    end else if (cmd.rem && ge) begin
      value <= right.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_flags) begin
      lt <= valid && (value < cmd.value);
      eq <= valid && (value == cmd.value);
      ge <= RANK >= 32'(cmd.position);
      at <= RANK == 32'(cmd.position);
    end
  end

  assign link.lt        = lt;
  assign link.valid     = valid;
  assign link.value     = value;
  assign stat.eq        = eq;
  assign stat.rd_value  = at ? value : '0;

endmodule

[hw/rtl/sorted_unique_set.sv]
// Sorted set of up to CAPACITY distinct signed 32-bit values, held in a row
// of cells in ascending order. A request is an insert, a read at a 1-based
// rank, or a remove at a rank, and each gives one result with the value read
// or removed, a status and the count after the request. Every request has
// two steps: in the first, all cells compare their entry with the request
// and record the outcome; in the second, the control combines those flags and
// the cells shift their entries in one step. No new request is taken until
// the second step is over. Results leave through a
// two-entry output stage, so one result may wait at the output while the next
// request is taken; only when both entries are full does the input stall until
// the result side takes one.
`include "sorted_unique_set_macros.svh"

module sorted_unique_set #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value [31:0], position [37:32], zero [39:38]
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_value [31:0], status [33:32], count [39:34]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (CW > sus_pkg::POS_W) ? CW : sus_pkg::POS_W;

  sus_pkg::state_t state;
  sus_pkg::state_t state_next;

  logic                                accept;
  logic                                exec;
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       count_next;
  logic [sus_pkg::REQ_W-1:0]           req_type;
  logic [sus_pkg::POS_W-1:0]           position;
  logic [39:0]                         result;
  logic [39:0]                         out_data;
  logic [39:0]                         spare_data;
  logic                                spare_valid;
  logic [sus_pkg::DATA_W-1:0]          rv_next;
  logic [sus_pkg::STAT_W-1:0]          st_next;
  logic                                dup;
  logic [sus_pkg::DATA_W-1:0]          rd_value;
  logic                                in_range;
  logic                                full;
  logic                                do_ins;
  logic                                do_rem;

  sus_pkg::cell_cmd_t  cmd;
  sus_pkg::cell_link_t links [CAPACITY];
  sus_pkg::cell_stat_t stats [CAPACITY];

  // Cell zero sees a left neighbor that is below any value and valid, so an
  // insert lands there when nothing smaller is stored.
  localparam sus_pkg::cell_link_t LEFT_END  = '{lt: 1'b1, valid: 1'b1, value: '0};
  localparam sus_pkg::cell_link_t RIGHT_END = '{lt: 1'b0, valid: 1'b0, value: '0};

  assign accept = s_tvalid && s_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sus_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = sus_pkg::ST_EXEC;
        end
      end
      sus_pkg::ST_EXEC: begin
        state_next = sus_pkg::ST_IDLE;
      end
      default: begin
        state_next = sus_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready = 1'b0;
    exec     = 1'b0;
    case (state)
      sus_pkg::ST_IDLE: begin
        s_tready = !spare_valid;
      end
      sus_pkg::ST_EXEC: begin
        exec = 1'b1;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sus_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type <= s_tuser;
      position <= s_tdata[37:32];
    end
  end

  always_comb begin
    dup      = 1'b0;
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      dup      = dup | stats[i].eq;
      rd_value = rd_value | stats[i].rd_value;
    end
  end

  assign full     = count == CW'(CAPACITY);
  assign in_range = (position != '0) && (RW'(position) <= RW'(count));

  always_comb begin
    rv_next    = '0;
    st_next    = sus_pkg::STAT_OK;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    count_next = count;
    case (req_type)
      sus_pkg::REQ_INSERT: begin
        if (dup) begin
          st_next = sus_pkg::STAT_DUP;
        end else if (full) begin
          st_next = sus_pkg::STAT_FULL;
        end else begin
          do_ins     = exec;
          count_next = count + CW'(1);
        end
      end
      sus_pkg::REQ_READ: begin
        if (!in_range) begin
          st_next = sus_pkg::STAT_RANGE;
        end else begin
          rv_next = rd_value;
        end
      end
      sus_pkg::REQ_REMOVE: begin
        if (!in_range) begin
          st_next = sus_pkg::STAT_RANGE;
        end else begin
          rv_next    = rd_value;
          do_rem     = exec;
          count_next = count - CW'(1);
        end
      end
      default: begin
        st_next = sus_pkg::STAT_OK;
      end
    endcase
  end

  assign cmd.load_flags = accept;
  assign cmd.ins        = do_ins;
  assign cmd.rem        = do_rem;
  assign cmd.value      = s_tdata[31:0];
  assign cmd.position   = s_tdata[37:32];

  // The insert value is needed in the execute cycle, after the input has
  // moved on, so it is held here and muxed onto the broadcast.
  logic signed [sus_pkg::DATA_W-1:0] ins_value;

  always_ff @(posedge clk) begin
    if (accept) begin
      ins_value <= s_tdata[31:0];
    end
  end

  sus_pkg::cell_cmd_t cell_cmd;

  always_comb begin
    cell_cmd = cmd;
    if (exec) begin
      cell_cmd.value = ins_value;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sus_pkg::cell_link_t left_in;
    sus_pkg::cell_link_t right_in;

    if (g == 0) begin : g_first
      assign left_in = LEFT_END;
    end else begin : g_mid_l
      assign left_in = links[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_in = RIGHT_END;
    end else begin : g_mid_r
      assign right_in = links[g+1];
    end

    sus_cell #(
      .INDEX (g)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cell_cmd),
      .left  (left_in),
      .right (right_in),
      .link  (links[g]),
      .stat  (stats[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec) begin
      count <= count_next;
    end
  end

  assign result = {sus_pkg::POS_W'(count_next), st_next, rv_next};

  // A result that finds the output register still waiting goes to the spare
  // register and moves up once the waiting one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      spare_valid <= 1'b0;
    end else if (exec) begin
      if (m_tvalid && !m_tready) begin
        spare_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end else if (m_tready) begin
      if (spare_valid) begin
        spare_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (m_tvalid && !m_tready) begin
        spare_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (m_tready && spare_valid) begin
      out_data <= spare_data;
    end
  end

  assign m_tdata = out_data;

  `SUS_ASSERT_SAME(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `SUS_ASSERT_NEXT(a_accept_exec, clk, rst, accept, exec && !s_tready)
  `SUS_ASSERT_NEXT(a_exec_result, clk, rst, exec, m_tvalid)
  `SUS_ASSERT_NEXT(a_count_hold, clk, rst, !exec, $stable(count))

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int CAPACITY = 32;
  localparam logic [sus_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1750;
  localparam int QUIET_TAIL = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIR_ROWS = 22;

  localparam logic signed [sus_pkg::DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [sus_pkg::DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [sus_pkg::DATA_W-1:0] read_value;
    logic [sus_pkg::STAT_W-1:0] status;
    logic [sus_pkg::POS_W-1:0]  count;
  } set_reply_t;

  typedef struct packed {
    logic [sus_pkg::REQ_W-1:0]         kind;
    logic signed [sus_pkg::DATA_W-1:0] value;
    logic [sus_pkg::POS_W-1:0]         rank;
    logic                              typed;
    set_reply_t                        reply;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // value [31:0], position [37:32], zero [39:38]
  logic [1:0]  s_tuser = '0;  // req_type [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // read_value [31:0], status [33:32], count [39:34]

  // Mirror of the set contents, ascending.
  logic signed [sus_pkg::DATA_W-1:0] set_entries [$];
  set_reply_t awaited_replies [$];

  dir_row_t dir_table [DIR_ROWS];
  int error_count = 0;
  int cycle_count = 0;
  int accepted_items = 0;
  int send_idle_pct = 10;
  int sink_stall_pct = 10;
  bit quiet_tail = 1'b0;

  sorted_unique_set #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic set_reply_t predict_set_request(
    input logic [sus_pkg::REQ_W-1:0] kind,
    input logic signed [sus_pkg::DATA_W-1:0] v,
    input logic [sus_pkg::POS_W-1:0] rank
  );
    set_reply_t r;
    int k;
    r = '0;
    r.status = sus_pkg::STAT_OK;
    case (kind)
      sus_pkg::REQ_INSERT: begin
        k = 0;
        while (k < set_entries.size() && set_entries[k] < v) k++;
        if (k < set_entries.size() && set_entries[k] == v) begin
          r.status = sus_pkg::STAT_DUP;
        end else if (set_entries.size() >= CAPACITY) begin
          r.status = sus_pkg::STAT_FULL;
        end else begin
          set_entries.insert(k, v);
        end
      end
      sus_pkg::REQ_READ, sus_pkg::REQ_REMOVE: begin
        if (rank == 0 || int'(rank) > set_entries.size()) begin
          r.status = sus_pkg::STAT_RANGE;
        end else begin
          r.read_value = set_entries[rank - 1];
          if (kind == sus_pkg::REQ_REMOVE) set_entries.delete(rank - 1);
        end
      end
      default: ;
    endcase
    r.count = sus_pkg::POS_W'(set_entries.size());
    return r;
  endfunction

  // Mix of narrow values (to provoke duplicates), extremes, stored values
  // and full-width random patterns.
  function automatic logic signed [sus_pkg::DATA_W-1:0] pick_value();
    int t;
    case ($urandom_range(0, 5))
      0, 1: begin
        t = $urandom_range(0, 16);
        return t - 8;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return INT_MIN;
          1: return INT_MAX;
          2: return -1;
          default: return 0;
        endcase
      end
      3: begin
        if (set_entries.size() == 0) return $urandom;
        return set_entries[$urandom_range(0, set_entries.size() - 1)];
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [sus_pkg::POS_W-1:0] pick_rank();
    int n;
    n = set_entries.size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return sus_pkg::POS_W'(n + 1);
      2: return sus_pkg::POS_W'($urandom_range(0, 63));
      3: return sus_pkg::POS_W'(n);
      default: return (n == 0) ? 6'd1 : sus_pkg::POS_W'($urandom_range(1, n));
    endcase
  endfunction

  // Sends one request; returns at the edge where it was taken. The caller
  // must drive the next request or drop valid in that same step.
  task automatic send_request(
    input logic [sus_pkg::REQ_W-1:0] kind,
    input logic signed [sus_pkg::DATA_W-1:0] v,
    input logic [sus_pkg::POS_W-1:0] rank,
    input bit typed,
    input set_reply_t typed_reply
  );
    set_reply_t predicted;
    if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, rank, v};
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_set_request(kind, v, rank);
    awaited_replies.push_back(typed ? typed_reply : predicted);
    if (kind != REQ_UNUSED) accepted_items++;
  endtask

  task automatic send_random(input logic [sus_pkg::REQ_W-1:0] kind);
    send_request(kind, pick_value(), pick_rank(), 1'b0, '0);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall bursts, none in the closing stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 99) < sink_stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    set_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
        error_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (m_tdata[31:0] !== want.read_value) begin
          $display("%0t: read_value expected %h, got %h",
                   $time, want.read_value, m_tdata[31:0]);
          error_count++;
        end
        if (m_tdata[33:32] !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, m_tdata[33:32]);
          error_count++;
        end
        if (m_tdata[39:34] !== want.count) begin
          $display("%0t: count expected %0d, got %0d", $time, want.count, m_tdata[39:34]);
          error_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int n;
    int base_items;
    dir_table = '{
      '{sus_pkg::REQ_READ,   32'sd0,  6'd1,  1'b1, '{32'h0,   sus_pkg::STAT_RANGE, 6'd0}},
      '{sus_pkg::REQ_REMOVE, 32'sd0,  6'd0,  1'b1, '{32'h0,   sus_pkg::STAT_RANGE, 6'd0}},
      '{sus_pkg::REQ_INSERT, INT_MAX, 6'd0,  1'b1, '{32'h0,   sus_pkg::STAT_OK,    6'd1}},
      '{sus_pkg::REQ_INSERT, INT_MIN, 6'd0,  1'b1, '{32'h0,   sus_pkg::STAT_OK,    6'd2}},
      '{sus_pkg::REQ_INSERT, INT_MAX, 6'd0,  1'b1, '{32'h0,   sus_pkg::STAT_DUP,   6'd2}},
      '{sus_pkg::REQ_READ,   32'sd0,  6'd1,  1'b1, '{INT_MIN, sus_pkg::STAT_OK,    6'd2}},
      '{sus_pkg::REQ_READ,   32'sd0,  6'd2,  1'b1, '{INT_MAX, sus_pkg::STAT_OK,    6'd2}},
      '{sus_pkg::REQ_READ,   32'sd0,  6'd3,  1'b1, '{32'h0,   sus_pkg::STAT_RANGE, 6'd2}},
      '{sus_pkg::REQ_READ,   32'sd0,  6'd0,  1'b1, '{32'h0,   sus_pkg::STAT_RANGE, 6'd2}},
      '{REQ_UNUSED, 32'sh1234_5678,   6'd1,  1'b1, '{32'h0,   sus_pkg::STAT_OK,    6'd2}},
      '{sus_pkg::REQ_READ,   32'sd0,  6'd63, 1'b1, '{32'h0,   sus_pkg::STAT_RANGE, 6'd2}},
      '{sus_pkg::REQ_INSERT, 32'sd0,         6'd0,  1'b0, '0},
      '{sus_pkg::REQ_INSERT, -32'sd1,        6'd0,  1'b0, '0},
      '{sus_pkg::REQ_INSERT, 32'sd1,         6'd0,  1'b0, '0},
      '{sus_pkg::REQ_INSERT, 32'sd0,         6'd0,  1'b0, '0},
      '{sus_pkg::REQ_READ,   32'sd0,         6'd3,  1'b0, '0},
      '{sus_pkg::REQ_REMOVE, 32'sd0,         6'd5,  1'b0, '0},
      '{sus_pkg::REQ_READ,   32'sd0,         6'd5,  1'b0, '0},
      '{sus_pkg::REQ_REMOVE, 32'sd0,         6'd1,  1'b0, '0},
      '{sus_pkg::REQ_REMOVE, 32'sd0,         6'd2,  1'b0, '0},
      '{sus_pkg::REQ_INSERT, 32'sh5a5a_5a5a, 6'd63, 1'b0, '0},
      '{sus_pkg::REQ_REMOVE, 32'shffff_ffff, 6'd33, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_table[i].kind, dir_table[i].value, dir_table[i].rank,
                   dir_table[i].typed, dir_table[i].reply);
    end
    hold_until_drained();

    base_items = accepted_items;
    while (accepted_items - base_items < RANDOM_ITEMS) begin
      quiet_tail = (accepted_items - base_items > RANDOM_ITEMS - QUIET_TAIL);
      send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      phase = $urandom_range(0, 4);
      case (phase)
        // Grow the set, often to full, with a few reads between.
        0: begin
          n = $urandom_range(20, 45);
          repeat (n) send_random(($urandom_range(0, 5) == 0) ? sus_pkg::REQ_READ
                                                             : sus_pkg::REQ_INSERT);
        end
        // Shrink it, hitting the head, the tail and bad ranks.
        1: begin
          n = $urandom_range(10, 40);
          repeat (n) send_random(($urandom_range(0, 4) == 0) ? sus_pkg::REQ_READ
                                                             : sus_pkg::REQ_REMOVE);
        end
        // Balanced traffic around a steady size.
        2: begin
          repeat (30) send_random(sus_pkg::REQ_W'($urandom_range(0, 2)));
        end
        // Noise: any code, any bits in value and position.
        3: begin
          repeat (20) send_request(sus_pkg::REQ_W'($urandom_range(0, 3)), $urandom,
                                   sus_pkg::POS_W'($urandom_range(0, 63)), 1'b0, '0);
        end
        default: begin
          if (!quiet_tail) hold_until_drained();
          repeat (10) send_random(sus_pkg::REQ_W'($urandom_range(0, 2)));
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
